FILE: design/sms_pkg.sv
`default_nettype none
// sms_pkg: shared types, widths and the double key compare for the merge sorter.
// Used by sms_front, sms_jobq, sms_back and the top level; depends on nothing.
package sms_pkg;

  localparam int CNT_W = 7;
  localparam int POS_W = 8;
  localparam int KEY_W = 64;
  localparam int TAG_MAX_W = 32;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } job_t;

  typedef struct packed {
    logic                 we;
    logic [POS_W-1:0]     addr;
    logic [KEY_W-1:0]     key;
    logic [TAG_MAX_W-1:0] tag;
  } ld_wr_t;

  // true when double x < double y; -0 equals +0; false when either is NaN
  function automatic logic key_less(input logic [KEY_W-1:0] x, input logic [KEY_W-1:0] y);
    logic [KEY_W-1:0] ox;
    logic [KEY_W-1:0] oy;
    logic nan_x;
    logic nan_y;
    ox = x[KEY_W-1] ? ~x : (x | {1'b1, {(KEY_W-1){1'b0}}});
    oy = y[KEY_W-1] ? ~y : (y | {1'b1, {(KEY_W-1){1'b0}}});
    nan_x = (&x[KEY_W-2:KEY_W-12]) && (x[KEY_W-13:0] != '0);
    nan_y = (&y[KEY_W-2:KEY_W-12]) && (y[KEY_W-13:0] != '0);
    if (nan_x || nan_y) begin
      key_less = 1'b0;
    end else if (x[KEY_W-2:0] == '0 && y[KEY_W-2:0] == '0) begin
      key_less = 1'b0;
    end else begin
      key_less = ox < oy;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/sms_ram.sv
`default_nettype none
// sms_ram: generic RAM, one write port and two registered read ports.
// No dependencies.
module sms_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

FILE: design/sms_front.sv
`default_nettype none
// sms_front: loader; stores words into bank 0, counts, flags overflow, posts a job on last.
// Depends on sms_pkg.
module sms_front #(
  parameter int MAX_ITEMS = 64,
  parameter int TW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic [63:0]   in_item_key,
  input  wire logic [15:0]   in_item_tag,
  input  wire logic          in_item_last,
  input  wire logic          done,
  output sms_pkg::ld_wr_t    ld_wr,
  output logic               job_push,
  output sms_pkg::job_t      job
);

  logic [sms_pkg::CNT_W-1:0] count_r, count_nxt;
  logic ovf_r, ovf_nxt;
  logic hold_r, hold_nxt;
  logic acc, room;

  assign in_full = hold_r;
  assign acc = in_push && !hold_r;
  assign room = count_r < sms_pkg::CNT_W'(MAX_ITEMS);

  always_comb begin
    ld_wr.we = acc && room;
    ld_wr.addr = sms_pkg::POS_W'(count_r);
    ld_wr.key = in_item_key;
    ld_wr.tag = sms_pkg::TAG_MAX_W'(in_item_tag[TW-1:0]);
    count_nxt = count_r;
    ovf_nxt = ovf_r;
    hold_nxt = hold_r;
    job_push = 1'b0;
    job.count = count_r;
    job.ovf = ovf_r;
    if (done) begin
      hold_nxt = 1'b0;
    end
    if (acc) begin
      if (room) begin
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_item_last) begin
        job_push = 1'b1;
        job.count = count_nxt;
        job.ovf = ovf_nxt;
        count_nxt = '0;
        ovf_nxt = 1'b0;
        hold_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
      hold_r <= hold_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_item_last |=> hold_r)
    else $error("front not holding after last word");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sms_pkg::CNT_W'(MAX_ITEMS))
    else $error("item count above maximum");
  a_no_write_held: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> !ld_wr.we)
    else $error("load write while sort owns memory");
`endif

endmodule
`default_nettype wire

FILE: design/sms_jobq.sv
`default_nettype none
// sms_jobq: two-entry queue of set descriptors between loader and sorter.
// Depends on sms_pkg.
module sms_jobq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sms_pkg::job_t din,
  input  wire logic          pop,
  output logic               valid,
  output sms_pkg::job_t      dout
);

  sms_pkg::job_t q_r [2];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign valid = cnt_r != 2'd0;
  assign dout = q_r[rp_r];
  assign do_push = push && cnt_r != 2'd2;
  assign do_pop = pop && valid;

  always_comb begin
    wp_nxt = do_push ? ~wp_r : wp_r;
    rp_nxt = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= din;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push)
    else $error("job queue overrun");
`endif

endmodule
`default_nettype wire

FILE: design/sms_back.sv
`default_nettype none
// sms_back: bottom-up merge passes over two ping-pong RAM banks, then drains words out.
// Depends on sms_pkg and sms_ram.
module sms_back #(
  parameter int MAX_ITEMS = 64,
  parameter int TW = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sms_pkg::ld_wr_t ld_wr,
  input  wire logic            job_valid,
  input  wire sms_pkg::job_t   job,
  output logic                 job_pop,
  output logic                 done,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [63:0]          out_sorted_key,
  output logic [15:0]          out_sorted_tag,
  output logic                 out_sorted_last,
  output logic                 out_overflow
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int DW = 64 + TW;
  localparam int PW = sms_pkg::POS_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRD  = 3'd1;
  localparam logic [2:0] ST_PWR  = 3'd2;
  localparam logic [2:0] ST_ORD  = 3'd3;
  localparam logic [2:0] ST_OWR  = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [PW-1:0] n_r, n_nxt, w_r, w_nxt, mid_r, mid_nxt, hi_r, hi_nxt;
  logic [PW-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic ovf_r, ovf_nxt, src_r, src_nxt;
  logic ov_r, ov_nxt;
  logic [63:0] okey_r, okey_nxt;
  logic [TW-1:0] otag_r, otag_nxt;
  logic olast_r, olast_nxt, oovf_r, oovf_nxt;

  logic [AW-1:0] ra_addr, rb_addr;
  logic [DW-1:0] rd0_a, rd0_b, rd1_a, rd1_b, ra, rb;
  logic bk_we;
  logic [DW-1:0] bk_wdata;
  logic we0, we1;
  logic [AW-1:0] wa0, wa1;
  logic [DW-1:0] wd0;
  logic take_right;
  logic [PW-1:0] kp1, wd2, s1, s2;

  function automatic logic [PW-1:0] min_n(input logic [PW-1:0] x, input logic [PW-1:0] n);
    min_n = (x > n) ? n : x;
  endfunction

  assign ra_addr = (st_r == ST_ORD || st_r == ST_OWR) ? k_r[AW-1:0] : a_r[AW-1:0];
  assign rb_addr = b_r[AW-1:0];
  assign ra = src_r ? rd1_a : rd0_a;
  assign rb = src_r ? rd1_b : rd0_b;

  assign we0 = (bk_we && src_r) || ld_wr.we;
  assign wa0 = ld_wr.we ? ld_wr.addr[AW-1:0] : k_r[AW-1:0];
  assign wd0 = ld_wr.we ? {ld_wr.key, ld_wr.tag[TW-1:0]} : bk_wdata;
  assign we1 = bk_we && !src_r;
  assign wa1 = k_r[AW-1:0];

  sms_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_bank0 (
    .clk(clk), .we(we0), .waddr(wa0), .wdata(wd0),
    .raddr_a(ra_addr), .raddr_b(rb_addr), .rdata_a(rd0_a), .rdata_b(rd0_b)
  );

  sms_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_bank1 (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(bk_wdata),
    .raddr_a(ra_addr), .raddr_b(rb_addr), .rdata_a(rd1_a), .rdata_b(rd1_b)
  );

  assign out_empty = !ov_r;
  assign out_sorted_key = okey_r;
  assign out_sorted_tag = 16'(otag_r);
  assign out_sorted_last = olast_r;
  assign out_overflow = oovf_r;

  always_comb begin
    st_nxt = st_r;
    n_nxt = n_r;
    w_nxt = w_r;
    mid_nxt = mid_r;
    hi_nxt = hi_r;
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    ovf_nxt = ovf_r;
    src_nxt = src_r;
    ov_nxt = ov_r && !out_pop;
    okey_nxt = okey_r;
    otag_nxt = otag_r;
    olast_nxt = olast_r;
    oovf_nxt = oovf_r;
    job_pop = 1'b0;
    done = 1'b0;
    bk_we = 1'b0;
    take_right = 1'b0;
    kp1 = k_r + 1'b1;
    wd2 = w_r << 1;
    s1 = '0;
    s2 = '0;
    if (b_r >= hi_r) begin
      take_right = 1'b0;
    end else if (a_r >= mid_r) begin
      take_right = 1'b1;
    end else begin
      take_right = sms_pkg::key_less(rb[DW-1:TW], ra[DW-1:TW]);
    end
    bk_wdata = take_right ? rb : ra;
    unique case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          n_nxt = PW'(job.count);
          ovf_nxt = job.ovf;
          src_nxt = 1'b0;
          k_nxt = '0;
          w_nxt = PW'(1);
          a_nxt = '0;
          mid_nxt = PW'(1);
          hi_nxt = min_n(PW'(2), PW'(job.count));
          b_nxt = PW'(1);
          st_nxt = (PW'(job.count) > PW'(1)) ? ST_PRD : ST_ORD;
        end
      end
      ST_PRD: begin
        st_nxt = ST_PWR;
      end
      ST_PWR: begin
        bk_we = 1'b1;
        k_nxt = kp1;
        if (take_right) begin
          b_nxt = b_r + 1'b1;
        end else begin
          a_nxt = a_r + 1'b1;
        end
        st_nxt = ST_PRD;
        if (kp1 == n_r) begin
          w_nxt = wd2;
          src_nxt = ~src_r;
          k_nxt = '0;
          if (wd2 >= n_r) begin
            st_nxt = ST_ORD;
          end else begin
            s1 = min_n(wd2, n_r);
            s2 = min_n(wd2 << 1, n_r);
            a_nxt = '0;
            mid_nxt = s1;
            hi_nxt = s2;
            b_nxt = s1;
          end
        end else if (kp1 == hi_r) begin
          s1 = min_n(hi_r + w_r, n_r);
          s2 = min_n(hi_r + wd2, n_r);
          a_nxt = hi_r;
          mid_nxt = s1;
          hi_nxt = s2;
          b_nxt = s1;
        end
      end
      ST_ORD: begin
        st_nxt = ST_OWR;
      end
      ST_OWR: begin
        if (!ov_r || out_pop) begin
          ov_nxt = 1'b1;
          okey_nxt = ra[DW-1:TW];
          otag_nxt = ra[TW-1:0];
          olast_nxt = kp1 == n_r;
          oovf_nxt = ovf_r;
          k_nxt = kp1;
          if (kp1 == n_r) begin
            done = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            st_nxt = ST_ORD;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    w_r <= w_nxt;
    mid_r <= mid_nxt;
    hi_r <= hi_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    ovf_r <= ovf_nxt;
    src_r <= src_nxt;
    okey_r <= okey_nxt;
    otag_r <= otag_nxt;
    olast_r <= olast_nxt;
    oovf_r <= oovf_nxt;
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

`ifndef SYNTHESIS
  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_PWR |-> a_r <= mid_r && b_r <= hi_r && k_r < n_r)
    else $error("merge pointers out of run");
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_OWR |-> k_r < n_r)
    else $error("drain past set size");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> ov_r && olast_r)
    else $error("set finished without last word");
`endif

endmodule
`default_nettype wire

FILE: design/stable_merge_sort_with_tags.sv
`default_nettype none
// stable_merge_sort_with_tags: top level, loader, job queue and merge sorter.
// Depends on sms_pkg, sms_front, sms_jobq, sms_back (sms_ram).
//
// Usage:
//   Input is a queue: a word (key, tag, last) is taken when in_push is high and
//   in_full is low. Words gather into a set; the word with in_item_last closes it.
//   Beyond MAX_ITEMS words the extras are dropped and out_overflow is set on every
//   result of that set. Only the low TAG_BITS of the tag are kept.
//   Results form a queue: while out_empty is low the oldest sorted word is shown;
//   out_pop takes it. out_sorted_last marks the final word of the set.
//   Keys sort ascending as doubles (-0 equals +0), stable on equal keys.
// Timing:
//   Loading accepts one word per cycle while in_full is low. After the last word
//   in_full stays high until the last sorted word of the set has moved into the
//   output register. The sort runs ceil(log2 n) merge passes; for each word a pass
//   reads both run heads from the registered RAM read ports, then compares and
//   writes. The drain reads each word, then moves it into the output register.
//   A stalled receiver holds the drain; nothing is lost.
// Reset: rst_n low at a clock edge empties both queues and drops any partial set.
module stable_merge_sort_with_tags #(
  parameter int MAX_ITEMS = 64,
  parameter int TAG_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [63:0] in_item_key,
  input  wire logic [15:0] in_item_tag,
  input  wire logic        in_item_last,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [63:0]      out_sorted_key,
  output logic [15:0]      out_sorted_tag,
  output logic             out_sorted_last,
  output logic             out_overflow
);

  localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;

  sms_pkg::ld_wr_t ld_wr;
  sms_pkg::job_t job_in, job_out;
  logic job_push, job_pop, job_valid, done;

  sms_front #(.MAX_ITEMS(MAX_ITEMS), .TW(TW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_item_key(in_item_key), .in_item_tag(in_item_tag), .in_item_last(in_item_last),
    .done(done), .ld_wr(ld_wr), .job_push(job_push), .job(job_in)
  );

  sms_jobq u_jobq (
    .clk(clk), .rst_n(rst_n),
    .push(job_push), .din(job_in),
    .pop(job_pop), .valid(job_valid), .dout(job_out)
  );

  sms_back #(.MAX_ITEMS(MAX_ITEMS), .TW(TW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .ld_wr(ld_wr), .job_valid(job_valid), .job(job_out), .job_pop(job_pop),
    .done(done), .out_empty(out_empty), .out_pop(out_pop),
    .out_sorted_key(out_sorted_key), .out_sorted_tag(out_sorted_tag),
    .out_sorted_last(out_sorted_last), .out_overflow(out_overflow)
  );

endmodule
`default_nettype wire
